[sv/gps_sector_line_crossing_unit_macros.svh]
// ----------------------------------------------------------------------------
// GPS sector line crossing unit - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef GPS_SECTOR_LINE_CROSSING_UNIT_MACROS_SVH
`define GPS_SECTOR_LINE_CROSSING_UNIT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define GSLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// consequent checked in the same cycle as the antecedent
`define GSLC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[sv/gslc_pkg.sv]
// ----------------------------------------------------------------------------
// gslc_pkg
// Shared types and constants of the GPS sector line crossing unit.
// ----------------------------------------------------------------------------
package gslc_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int NUM_SECTORS    = 3;

  typedef logic [2:0] reg_index_t;
  typedef logic [1:0] sector_t;

  localparam reg_index_t REG_SECTOR0_A = 3'd0;
  localparam reg_index_t REG_SECTOR0_B = 3'd1;
  localparam reg_index_t REG_SECTOR1_A = 3'd2;
  localparam reg_index_t REG_SECTOR1_B = 3'd3;
  localparam reg_index_t REG_SECTOR2_A = 3'd4;
  localparam reg_index_t REG_SECTOR2_B = 3'd5;
  localparam reg_index_t REG_ACTIVE    = 3'd6;

  localparam sector_t SECTOR0    = 2'd0;
  localparam sector_t SECTOR1    = 2'd1;
  localparam sector_t SECTOR2    = 2'd2;
  localparam sector_t SECTOR_NONE = 2'd3;

  typedef enum logic [1:0] {
    ORIENT_ZERO,
    ORIENT_POS,
    ORIENT_NEG
  } orient_t;

endpackage

[sv/gslc_orient.sv]
// ----------------------------------------------------------------------------
// gslc_orient
// One orientation lane: registered cross-product pair and its sign class.
// ----------------------------------------------------------------------------
module gslc_orient #(
  parameter int DW = gslc_pkg::COORD_BITS_DEF + 1
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic signed [DW-1:0] a0,
  input  logic signed [DW-1:0] a1,
  input  logic signed [DW-1:0] b0,
  input  logic signed [DW-1:0] b1,
  output gslc_pkg::orient_t    cls
);
  import gslc_pkg::*;

  localparam int PW = 2 * DW;

  logic signed [PW-1:0] p;
  logic signed [PW-1:0] q;

  always_ff @(posedge clk) begin
    if (load) begin
      p <= PW'(a0) * PW'(a1);
      q <= PW'(b0) * PW'(b1);
    end
  end

  always_comb begin
    if (p == q) begin
      cls = ORIENT_ZERO;
    end else if (p > q) begin
      cls = ORIENT_POS;
    end else begin
      cls = ORIENT_NEG;
    end
  end

endmodule

[sv/gps_sector_line_crossing_unit.sv]
// ----------------------------------------------------------------------------
// gps_sector_line_crossing_unit
// Tests each GPS path segment against a configured sector waypoint line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one fix (fix_lat, fix_lng) and
//   the sector to test. A transaction completes when in_valid is high and
//   in_stall is low. Each fix shifts into a previous/current history and
//   yields one line_crossed result on the output channel (out_valid/out_stall).
//   Configuration: write_enable, write_index, write_data; indices 0..5 hold
//   the line ends of sectors 0..2, index 6 the active mask, index 7 is ignored.
//   Write only while no transaction is in flight.
//   Throughput: one fix per cycle unless out_stall holds the output; the
//   four-lane cross-product multiplier is stage 3, and each of the four
//   stages holds one transaction.
//   Reset (rst, synchronous): clears history, line registers, mask and all
//   stage valids.
//   Output stall: the result register holds; upper stages keep accepting
//   until they fill, then in_stall rises.
// ----------------------------------------------------------------------------
module gps_sector_line_crossing_unit #(
  parameter int COORD_BITS = gslc_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write_enable,
  input  gslc_pkg::reg_index_t write_index,
  input  logic [63:0]          write_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [30:0]          fix_lat,
  input  logic [31:0]          fix_lng,
  input  gslc_pkg::sector_t    sector_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 line_crossed
);
  import gslc_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = COORD_BITS + 1;

  logic [63:0] point_a [NUM_SECTORS];
  logic [63:0] point_b [NUM_SECTORS];
  logic [2:0]  active_mask;

  logic signed [C-1:0] prev_lat, prev_lng, curr_lat, curr_lng;

  logic v1, v2, v3;
  logic ready1, ready2, ready3, ready4;
  logic accept;

  logic [31:0]         fix_lat_ext;
  logic signed [C-1:0] cu_lat_next, cu_lng_next;
  logic [63:0]         sel_a, sel_b;
  logic                sel_en;

  logic signed [C-1:0] s1_pv_lat, s1_pv_lng, s1_cu_lat, s1_cu_lng;
  logic signed [C-1:0] s1_la_lat, s1_la_lng, s1_lb_lat, s1_lb_lng;
  logic                s1_en;

  logic signed [DW-1:0] d_seg_lng, d_seg_lat;
  logic signed [DW-1:0] d_la_lat_pv, d_la_lng_pv, d_lb_lat_pv, d_lb_lng_pv;
  logic signed [DW-1:0] d_line_lng, d_line_lat;
  logic signed [DW-1:0] d_pv_lat_la, d_pv_lng_la, d_cu_lat_la, d_cu_lng_la;
  logic                 s2_en;
  logic                 s3_en;

  orient_t c0, c1, c2, c3;
  logic    hit;

  assign ready4   = !out_valid || !out_stall;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;
  assign accept   = in_valid && ready1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SECTORS; i++) begin
        point_a[i] <= '0;
        point_b[i] <= '0;
      end
      active_mask <= '0;
    end else if (write_enable) begin
      case (write_index)
        REG_SECTOR0_A: point_a[0] <= write_data;
        REG_SECTOR0_B: point_b[0] <= write_data;
        REG_SECTOR1_A: point_a[1] <= write_data;
        REG_SECTOR1_B: point_b[1] <= write_data;
        REG_SECTOR2_A: point_a[2] <= write_data;
        REG_SECTOR2_B: point_b[2] <= write_data;
        REG_ACTIVE:    active_mask <= write_data[2:0];
        default: ;
      endcase
    end
  end

  assign fix_lat_ext = {fix_lat[30], fix_lat};
  assign cu_lat_next = fix_lat_ext[C-1:0];
  assign cu_lng_next = fix_lng[C-1:0];

  always_comb begin
    case (sector_index)
      SECTOR0: begin
        sel_a = point_a[0]; sel_b = point_b[0]; sel_en = active_mask[0];
      end
      SECTOR1: begin
        sel_a = point_a[1]; sel_b = point_b[1]; sel_en = active_mask[1];
      end
      SECTOR2: begin
        sel_a = point_a[2]; sel_b = point_b[2]; sel_en = active_mask[2];
      end
      default: begin
        sel_a = '0; sel_b = '0; sel_en = 1'b0;
      end
    endcase
  end

  // position history
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_lat <= '0;
      prev_lng <= '0;
      curr_lat <= '0;
      curr_lng <= '0;
    end else if (accept) begin
      prev_lat <= curr_lat;
      prev_lng <= curr_lng;
      curr_lat <= cu_lat_next;
      curr_lng <= cu_lng_next;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) out_valid <= v3;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pv_lat <= curr_lat;
      s1_pv_lng <= curr_lng;
      s1_cu_lat <= cu_lat_next;
      s1_cu_lng <= cu_lng_next;
      s1_la_lat <= sel_a[32+C-1:32];
      s1_la_lng <= sel_a[C-1:0];
      s1_lb_lat <= sel_b[32+C-1:32];
      s1_lb_lng <= sel_b[C-1:0];
      s1_en     <= sel_en;
    end
  end

  // stage 2: coordinate differences
  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      d_seg_lng   <= DW'(s1_cu_lng) - DW'(s1_pv_lng);
      d_seg_lat   <= DW'(s1_cu_lat) - DW'(s1_pv_lat);
      d_la_lat_pv <= DW'(s1_la_lat) - DW'(s1_pv_lat);
      d_la_lng_pv <= DW'(s1_la_lng) - DW'(s1_pv_lng);
      d_lb_lat_pv <= DW'(s1_lb_lat) - DW'(s1_pv_lat);
      d_lb_lng_pv <= DW'(s1_lb_lng) - DW'(s1_pv_lng);
      d_line_lng  <= DW'(s1_lb_lng) - DW'(s1_la_lng);
      d_line_lat  <= DW'(s1_lb_lat) - DW'(s1_la_lat);
      d_pv_lat_la <= DW'(s1_pv_lat) - DW'(s1_la_lat);
      d_pv_lng_la <= DW'(s1_pv_lng) - DW'(s1_la_lng);
      d_cu_lat_la <= DW'(s1_cu_lat) - DW'(s1_la_lat);
      d_cu_lng_la <= DW'(s1_cu_lng) - DW'(s1_la_lng);
      s2_en       <= s1_en;
    end
  end

  // stage 3: cross products
  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      s3_en <= s2_en;
    end
  end

  gslc_orient #(.DW(DW)) u_orient_seg_a (
    .clk(clk), .load(ready3 && v2),
    .a0(d_seg_lng), .a1(d_la_lat_pv), .b0(d_seg_lat), .b1(d_la_lng_pv),
    .cls(c0)
  );

  gslc_orient #(.DW(DW)) u_orient_seg_b (
    .clk(clk), .load(ready3 && v2),
    .a0(d_seg_lng), .a1(d_lb_lat_pv), .b0(d_seg_lat), .b1(d_lb_lng_pv),
    .cls(c1)
  );

  gslc_orient #(.DW(DW)) u_orient_line_pv (
    .clk(clk), .load(ready3 && v2),
    .a0(d_line_lng), .a1(d_pv_lat_la), .b0(d_line_lat), .b1(d_pv_lng_la),
    .cls(c2)
  );

  gslc_orient #(.DW(DW)) u_orient_line_cu (
    .clk(clk), .load(ready3 && v2),
    .a0(d_line_lng), .a1(d_cu_lat_la), .b0(d_line_lat), .b1(d_cu_lng_la),
    .cls(c3)
  );

  // stage 4: result register
  assign hit = s3_en && (c0 != c1) && (c2 != c3);

  always_ff @(posedge clk) begin
    if (ready4 && v3) begin
      line_crossed <= hit;
    end
  end

endmodule

[sv/gslc_checker.sv]
// ----------------------------------------------------------------------------
// gslc_checker
// Port-level assertions for the GPS sector line crossing unit.
// ----------------------------------------------------------------------------
`include "gps_sector_line_crossing_unit_macros.svh"

module gslc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input gslc_pkg::sector_t    sector_index,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 line_crossed
);
  import gslc_pkg::*;

  logic in_acc;
  logic no_sec;

  assign in_acc = in_valid && !in_stall;
  assign no_sec = in_acc && (sector_index == SECTOR_NONE);

  `GSLC_ASSERT_NEXT(a_out_valid_hold, clk, rst, out_valid && out_stall, out_valid)

  `GSLC_ASSERT_NEXT(a_out_data_hold, clk, rst, out_valid && out_stall, $stable(line_crossed))

  `GSLC_ASSERT_NEXT(a_latency, clk, rst, in_acc ##1 !out_stall [*3], out_valid)

  `GSLC_ASSERT_NEXT(a_no_sector, clk, rst, no_sec ##1 !out_stall [*3], out_valid && !line_crossed)

endmodule

bind gps_sector_line_crossing_unit gslc_checker u_gslc_checker (.*);

[tb/sv/gps_sector_line_crossing_unit_tb.sv]
// ----------------------------------------------------------------------------
// gps_sector_line_crossing_unit_tb
// Self-checking bench: drives GPS fixes with sector indexes through the
// valid/stall channels, predicts each line_crossed flag with an exact
// orientation-class segment test, and compares every result in order.
// Covers directed edge cases, then random fixes at several line setups,
// with sender/receiver idling phases and a long receiver hold-off.
// ----------------------------------------------------------------------------
module gps_sector_line_crossing_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gslc_pkg::*;

  typedef enum {SCALE_SMALL, SCALE_GPS, SCALE_FULL} coord_scale_t;

  typedef struct packed {
    logic [31:0] lat;
    logic [31:0] lng;
  } point_t;

  localparam reg_index_t REG_UNUSED = 3'd7;

  class crossing_scoreboard;
    logic [63:0] line_end [6];
    logic [2:0]  active_mask;
    point_t      prev_pos;
    point_t      curr_pos;
    bit          crossing_q[$];
    int          errors;
    int          checked;
    int          crossings;

    function new();
      foreach (line_end[i]) line_end[i] = '0;
      active_mask = '0;
      prev_pos    = '0;
      curr_pos    = '0;
      errors      = 0;
      checked     = 0;
      crossings   = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [63:0] data);
      if (idx == REG_ACTIVE) begin
        active_mask = data[2:0];
      end else if (idx != REG_UNUSED) begin
        line_end[idx] = data;
      end
    endfunction

    function int pending();
      return crossing_q.size();
    endfunction

    // sign of (b - a) x (c - a), evaluated exactly
    function orient_t orientation(point_t a, point_t b, point_t c);
      logic signed [32:0] d_lng_ab, d_lat_ac, d_lat_ab, d_lng_ac;
      logic signed [65:0] p, q;
      d_lng_ab = {b.lng[31], b.lng} - {a.lng[31], a.lng};
      d_lat_ac = {c.lat[31], c.lat} - {a.lat[31], a.lat};
      d_lat_ab = {b.lat[31], b.lat} - {a.lat[31], a.lat};
      d_lng_ac = {c.lng[31], c.lng} - {a.lng[31], a.lng};
      p = d_lng_ab * d_lat_ac;
      q = d_lat_ab * d_lng_ac;
      if (p == q) return ORIENT_ZERO;
      return (p > q) ? ORIENT_POS : ORIENT_NEG;
    endfunction

    function void note_fix(logic [30:0] lat, logic [31:0] lng, sector_t sec);
      point_t end_a, end_b;
      bit     hit;
      prev_pos     = curr_pos;
      curr_pos.lat = {lat[30], lat};
      curr_pos.lng = lng;
      hit = 1'b0;
      if (sec != SECTOR_NONE && active_mask[sec]) begin
        end_a = line_end[2 * sec];
        end_b = line_end[2 * sec + 1];
        hit = orientation(prev_pos, curr_pos, end_a) != orientation(prev_pos, curr_pos, end_b)
           && orientation(end_a, end_b, prev_pos) != orientation(end_a, end_b, curr_pos);
      end
      crossing_q.push_back(hit);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    task check_result(logic got);
      bit want;
      if (crossing_q.size() == 0) begin
        report($sformatf("result with nothing pending, line_crossed=%b", got));
        return;
      end
      want = crossing_q.pop_front();
      checked++;
      if (want) crossings++;
      if (got !== want) begin
        report($sformatf("result %0d line_crossed=%b, predicted %b", checked, got, want));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        write_enable;
  reg_index_t  write_index;
  logic [63:0] write_data;
  logic        in_valid;
  logic        in_stall;
  logic [30:0] fix_lat;
  logic [31:0] fix_lng;
  sector_t     sector_index;
  logic        out_valid;
  logic        out_stall;
  logic        line_crossed;

  crossing_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int hold_left;
  int fixes_sent;

  gps_sector_line_crossing_unit dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .fix_lat      (fix_lat),
    .fix_lng      (fix_lng),
    .sector_index (sector_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_crossed (line_crossed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("gps_sector_line_crossing_unit verification failed");
    $finish;
  end

  // result side: check, then pick next stall (long hold-off takes priority)
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(line_crossed);
      if (rst) begin
        out_stall <= 1'b0;
      end else if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic [63:0] pack_point(int lat, int lng);
    return {32'(lat), 32'(lng)};
  endfunction

  function automatic logic [31:0] rand_coord(coord_scale_t scale, bit is_lat);
    logic [31:0] v;
    case (scale)
      SCALE_SMALL: v = $urandom_range(128) - 32'd64;
      SCALE_GPS: begin
        if (is_lat) v = $urandom_range(32'd1800000000) - 32'd900000000;
        else v = $urandom_range(32'd3600000000) - 32'd1800000000;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [63:0] data);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [63:0] s0a, logic [63:0] s0b, logic [63:0] s1a,
                           logic [63:0] s1b, logic [63:0] s2a, logic [63:0] s2b,
                           logic [2:0] mask);
    drain();
    repeat (8) @(posedge clk);
    write_reg(REG_SECTOR0_A, s0a);
    write_reg(REG_SECTOR0_B, s0b);
    write_reg(REG_SECTOR1_A, s1a);
    write_reg(REG_SECTOR1_B, s1b);
    write_reg(REG_SECTOR2_A, s2a);
    write_reg(REG_SECTOR2_B, s2b);
    write_reg(REG_UNUSED, {$urandom(), $urandom()});
    write_reg(REG_ACTIVE, {$urandom(), $urandom()} & ~64'h7 | 64'(mask));
    write_enable <= 1'b0;
  endtask

  task automatic send_fix(logic [30:0] lat, logic [31:0] lng, sector_t sec);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    fix_lat      <= lat;
    fix_lng      <= lng;
    sector_index <= sec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_fix(lat, lng, sec);
    fixes_sent++;
  endtask

  task automatic send_random(coord_scale_t cfg_scale);
    coord_scale_t s;
    logic [31:0]  lat, lng;
    s   = ($urandom_range(99) < 70) ? cfg_scale : coord_scale_t'($urandom_range(2));
    lat = rand_coord(s, 1'b1);
    lng = rand_coord(s, 1'b0);
    send_fix(lat[30:0], lng, sector_t'($urandom_range(3)));
  endtask

  initial begin
    logic [2:0]   masks [8];
    coord_scale_t scale;
    masks = '{3'b111, 3'b101, 3'b111, 3'b000, 3'b011, 3'b110, 3'b111, 3'b010};
    sb = new();
    idle_pct     = 0;
    stall_pct    = 0;
    hold_left    = 0;
    fixes_sent   = 0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    fix_lat      <= '0;
    fix_lng      <= '0;
    sector_index <= SECTOR0;
    write_enable <= 1'b0;
    write_index  <= REG_SECTOR0_A;
    write_data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sector 0: lat=0 line, sector 1: diagonal, sector 2: corner-to-corner (inactive)
    configure(pack_point(0, -100), pack_point(0, 100), pack_point(-50, -50),
              pack_point(50, 50), pack_point(32'h7FFFFFFF, 32'h80000000),
              pack_point(32'h80000000, 32'h7FFFFFFF), 3'b011);
    send_fix(50, 0, SECTOR0);           // first segment starts at origin, on the line
    send_fix(-50, 10, SECTOR0);
    send_fix(-60, 20, SECTOR0);
    send_fix(60, 200, SECTOR0);         // passes beyond line end
    send_fix(0, 300, SECTOR0);
    send_fix(0, -300, SECTOR0);         // collinear sweep
    send_fix(10, 10, SECTOR_NONE);
    send_fix(-10, -10, SECTOR2);        // inactive sector
    send_fix(10, -10, SECTOR1);
    send_fix(50, 50, SECTOR1);          // ends on line end
    send_fix(31'h3FFFFFFF, 32'h7FFFFFFF, SECTOR1);
    send_fix(31'h40000000, 32'h80000000, SECTOR1);
    send_fix(900000000, -1800000000, SECTOR0);
    send_fix(-900000000, 1800000000, SECTOR0);
    send_fix(31'h3FFFFFFF, 32'h80000000, SECTOR0);
    send_fix(31'h40000000, 32'h7FFFFFFF, SECTOR1);

    configure(pack_point(0, -100), pack_point(0, 100), pack_point(-50, -50),
              pack_point(50, 50), pack_point(32'h7FFFFFFF, 32'h80000000),
              pack_point(32'h80000000, 32'h7FFFFFFF), 3'b111);
    send_fix(900000000, -1800000000, SECTOR2);
    send_fix(-900000000, 1800000000, SECTOR2);
    send_fix(31'h3FFFFFFF, 32'h7FFFFFFF, SECTOR2);
    send_fix(31'h40000000, 32'h80000000, SECTOR2);
    send_fix(0, 0, SECTOR2);
    send_fix(0, 0, SECTOR2);            // zero-length segment

    for (int blk = 0; blk < 8; blk++) begin
      scale = coord_scale_t'(blk % 3);
      configure({rand_coord(scale, 1'b1), rand_coord(scale, 1'b0)},
                {rand_coord(scale, 1'b1), rand_coord(scale, 1'b0)},
                {rand_coord(scale, 1'b1), rand_coord(scale, 1'b0)},
                {rand_coord(scale, 1'b1), rand_coord(scale, 1'b0)},
                {rand_coord(scale, 1'b1), rand_coord(scale, 1'b0)},
                {rand_coord(scale, 1'b1), rand_coord(scale, 1'b0)}, masks[blk]);
      case (blk % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < 135; n++) begin
        if (blk == 0 && n == 40) hold_left = 250;
        if (blk == 1 && n == 70) drain();
        send_random(scale);
      end
    end

    drain();
    repeat (16) @(posedge clk);
    $display("sent %0d fixes (directed edge cases plus random small/GPS/full-range)",
             fixes_sent);
    $display("checked %0d results, %0d crossings, over 10 line setups",
             sb.checked, sb.crossings);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("gps_sector_line_crossing_unit verification clean");
    end else begin
      $display("gps_sector_line_crossing_unit verification failed");
    end
    $finish;
  end

endmodule
